// File: hdl/bstl_pkg.sv
// Package for the bounded sorted top list unit: transfer types, sizes,
// codes and the controller/datapath command and status structs.
// No dependencies.
package bstl_pkg;

  // List depth and name length
  localparam int ENTRIES    = 16;
  localparam int NAME_CHARS = 31;
  localparam int NAME_BYTES = 31;
  localparam int NAME_W     = 8 * NAME_BYTES;

  // Index and count widths follow the depth
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Result field widths
  localparam int SLOT_W   = 4;
  localparam int RANK_W   = 5;
  localparam int FILLED_W = 5;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] new_score;
    logic [63:0]        name_word0;
    logic [63:0]        name_word1;
    logic [63:0]        name_word2;
    logic [55:0]        name_word3;
    logic [31:0]        stamp;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [SLOT_W-1:0]   slot;
    logic [RANK_W-1:0]   rank;
    logic [FILLED_W-1:0] filled;
  } out_item_t;

  // One stored record
  typedef struct packed {
    logic signed [31:0] score;
    logic [NAME_W-1:0]  name;
    logic [31:0]        stamp;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input item, restart scan
    logic step;    // advance scan index
    logic latch;   // record scan outcome
    logic commit;  // update list, build result
    logic emit;    // move result to output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // current record matches (never when empty)
    logic scan_end;  // list empty or index at last valid record
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

// File: hdl/bounded_sorted_top_list_unit.sv
// Top level of the bounded sorted top list unit: controller plus datapath.
// Depends on bstl_pkg, bstl_ctrl and bstl_datapath.
//
// Keeps up to ENTRIES records (signed score, 31-byte name, timestamp) in
// descending score order; equal scores keep arrival order. An insert lands
// before the first record with a lower score, dropping the last record when
// the list is full, and is refused when it beats none of a full list. A rank
// query returns the 1-based position of the first equal score, or 0. One item
// is worked on at a time: after the accept cycle the unit compares one stored
// record per cycle through the record table's single read port, stopping at
// the first match or at the last valid record, then updates the list in the
// commit state and loads the output register in the respond state. While the
// previous result is still stalled in the output register, the respond state
// waits until that result transfers. Results sit in an output register, so
// a new item is taken while an earlier result still waits. The list is empty
// after reset.
module bounded_sorted_top_list_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bstl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bstl_pkg::out_item_t out_item_o
);
  import bstl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  bstl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Record table and result path
  bstl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/bstl_ctrl.sv
// Controller for the bounded sorted top list unit: accept, scan, commit,
// respond sequence. Depends on bstl_pkg.
module bstl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bstl_pkg::status_t status_i,
  output bstl_pkg::cmd_t    cmd_o
);
  import bstl_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.scan_end) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.scan_end) begin
          cmd_o.latch = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      ST_RESP: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/bstl_datapath.sv
// Datapath for the bounded sorted top list unit: item register, record
// table with shift-insert, scan compare, result and output registers.
// Depends on bstl_pkg.
module bstl_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bstl_pkg::in_item_t  in_item_i,
  input  bstl_pkg::cmd_t      cmd_i,
  output bstl_pkg::status_t   status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output bstl_pkg::out_item_t out_item_o
);
  import bstl_pkg::*;

  // Keep bytes up to the first zero byte, below NAME_CHARS
  function automatic logic [NAME_W-1:0] clip_name(logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (b >= NAME_CHARS || raw[b*8 +: 8] == 8'h00) live = 1'b0;
      if (live) res[b*8 +: 8] = raw[b*8 +: 8];
    end
    return res;
  endfunction

  logic               kind_q;
  logic signed [31:0] score_q;
  logic [NAME_W-1:0]  name_q;
  logic [31:0]        stamp_q;

  logic [IDX_W-1:0]   idx_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   pos_q;
  logic               found_q;

  rec_t               rec_q [ENTRIES];

  out_item_t          res_q, res_d;
  out_item_t          out_q;
  logic               out_valid_q;

  logic               empty, full, cmp, do_write;
  rec_t               rec_cur;
  rec_t               rec_new;

  // Scan compare against the record at the scan index
  assign rec_cur = rec_q[idx_q];
  assign empty   = (count_q == '0);
  assign full    = (count_q == CNT_W'(ENTRIES));
  assign cmp     = (kind_q == KIND_INSERT) ? (score_q > rec_cur.score)
                                           : (score_q == rec_cur.score);

  assign status_o.hit      = !empty && cmp;
  assign status_o.scan_end = empty || ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_item_i.kind;
      score_q <= in_item_i.new_score;
      name_q  <= clip_name({in_item_i.name_word3, in_item_i.name_word2,
                            in_item_i.name_word1, in_item_i.name_word0});
      stamp_q <= in_item_i.stamp;
    end
  end

  // Scan index and outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.latch) begin
        found_q <= status_o.hit;
        pos_q   <= status_o.hit ? CNT_W'(idx_q) : count_q;
      end
    end
  end

  // Commit decision and result
  assign do_write = (kind_q == KIND_INSERT) && (found_q || !full);

  always_comb begin
    count_d = count_q;
    if (do_write && !full) count_d = count_q + CNT_W'(1);
    res_d.accepted = (kind_q == KIND_QUERY) || do_write;
    res_d.slot     = do_write ? SLOT_W'(pos_q) : '0;
    res_d.rank     = ((kind_q == KIND_QUERY) && found_q) ?
                     RANK_W'(pos_q + CNT_W'(1)) : '0;
    res_d.filled   = FILLED_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= res_d;
  end

  // Record table: records below the insert point move down one place
  assign rec_new.score = score_q;
  assign rec_new.name  = name_q;
  assign rec_new.stamp = stamp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_write) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (CNT_W'(i) == pos_q) begin
          rec_q[i] <= rec_new;
        end else if (i > 0 && CNT_W'(i) > pos_q) begin
          rec_q[i] <= rec_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/bstl_checker.sv
// Port-level checks for the bounded sorted top list unit, bound to the top.
// Depends on bstl_pkg and bounded_sorted_top_list_unit.
module bstl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bstl_pkg::out_item_t out_item_o
);
  import bstl_pkg::*;

  // One item at a time: an input transfer closes the input side next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item still in work");

  // Fill never exceeds the list depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.filled <= FILLED_W'(ENTRIES)))
    else $error("filled beyond list depth");

  // A refused insert reports no slot and no rank
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.accepted) |->
      (out_item_o.slot == '0 && out_item_o.rank == '0))
    else $error("refused insert with slot or rank");

  // A rank found lies within the filled part of the list
  a_rank_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.rank != '0) |->
      (out_item_o.rank <= out_item_o.filled && out_item_o.slot == '0))
    else $error("rank outside filled list");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind bounded_sorted_top_list_unit bstl_checker u_bstl_checker (.*);
